// ===== sv/pidsp_pkg.sv =====
// ----------------------------------------------------------------------------
// PID speed/position controller package
// Shared widths, register map, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package pidsp_pkg;

   // Field widths
   localparam int DATA_W  = 16;   // measured, target, drive
   localparam int ERR_W   = 18;   // error after wrap handling
   localparam int GAIN_W  = 24;   // unsigned Q16.8 gains
   localparam int LIMIT_W = 15;   // drive and integral limits
   localparam int ACC_W   = 24;   // integral term in Q.8, always within +-(2^23 - 256)
   localparam int ADDR_W  = 5;    // seven 32-bit registers at 4*i
   localparam int CSR_W   = 32;

   // Encoder wrap handling in position mode
   localparam logic signed [DATA_W:0]  WRAP_HI   = 17'sd4096;
   localparam logic signed [DATA_W:0]  WRAP_LO   = -17'sd4096;
   localparam logic signed [ERR_W-1:0] WRAP_SPAN = 18'sd8191;

   // Register map, word index = paddr[4:2]
   typedef enum logic [2:0] {
      REG_LOOP_MODE        = 3'd0,
      REG_PROP_GAIN        = 3'd1,
      REG_INTEG_GAIN       = 3'd2,
      REG_DERIV_GAIN       = 3'd3,
      REG_DRIVE_LIMIT      = 3'd4,
      REG_INTEG_LIMIT      = 3'd5,
      REG_SEPARATION_LEVEL = 3'd6
   } reg_index_type;

   // Loop modes
   localparam logic MODE_SPEED    = 1'b0;
   localparam logic MODE_POSITION = 1'b1;

   // Reset values
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 24'd256;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd16384;

   typedef struct packed {
      logic                     loop_mode;
      logic [GAIN_W-1:0]        prop_gain;
      logic [GAIN_W-1:0]        integ_gain;
      logic [GAIN_W-1:0]        deriv_gain;
      logic [LIMIT_W-1:0]       drive_limit;
      logic [LIMIT_W-1:0]       integ_limit;
      logic signed [DATA_W-1:0] separation_level;
   } cfg_type;

endpackage

// ===== sv/pidsp_csr.sv =====
// ----------------------------------------------------------------------------
// PID controller register file
// APB-style slave holding the seven controller settings.
// ----------------------------------------------------------------------------
module pidsp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pidsp_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [pidsp_pkg::CSR_W-1:0]      csr_pwdata,
   output logic [pidsp_pkg::CSR_W-1:0]      csr_prdata,
   output logic                             csr_pready,
   output pidsp_pkg::cfg_type               cfg
);

   pidsp_pkg::cfg_type       cfg_ff;
   pidsp_pkg::reg_index_type reg_index;
   logic                     wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = pidsp_pkg::reg_index_type'(csr_paddr[pidsp_pkg::ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Write the addressed register, keeping its low bits only
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_mode        <= pidsp_pkg::MODE_SPEED;
         cfg_ff.prop_gain        <= pidsp_pkg::PROP_GAIN_RST;
         cfg_ff.integ_gain       <= '0;
         cfg_ff.deriv_gain       <= '0;
         cfg_ff.drive_limit      <= pidsp_pkg::DRIVE_LIMIT_RST;
         cfg_ff.integ_limit      <= '0;
         cfg_ff.separation_level <= '0;
      end else if (wr_en) begin
         unique case (reg_index)
            pidsp_pkg::REG_LOOP_MODE:
               cfg_ff.loop_mode <= csr_pwdata[0];
            pidsp_pkg::REG_PROP_GAIN:
               cfg_ff.prop_gain <= csr_pwdata[pidsp_pkg::GAIN_W-1:0];
            pidsp_pkg::REG_INTEG_GAIN:
               cfg_ff.integ_gain <= csr_pwdata[pidsp_pkg::GAIN_W-1:0];
            pidsp_pkg::REG_DERIV_GAIN:
               cfg_ff.deriv_gain <= csr_pwdata[pidsp_pkg::GAIN_W-1:0];
            pidsp_pkg::REG_DRIVE_LIMIT:
               cfg_ff.drive_limit <= csr_pwdata[pidsp_pkg::LIMIT_W-1:0];
            pidsp_pkg::REG_INTEG_LIMIT:
               cfg_ff.integ_limit <= csr_pwdata[pidsp_pkg::LIMIT_W-1:0];
            pidsp_pkg::REG_SEPARATION_LEVEL:
               cfg_ff.separation_level <= $signed(csr_pwdata[pidsp_pkg::DATA_W-1:0]);
            default: ;
         endcase
      end
   end

   // Read back, zero-extended
   always_comb begin
      csr_prdata = '0;
      unique case (reg_index)
         pidsp_pkg::REG_LOOP_MODE:
            csr_prdata = {31'd0, cfg_ff.loop_mode};
         pidsp_pkg::REG_PROP_GAIN:
            csr_prdata = {8'd0, cfg_ff.prop_gain};
         pidsp_pkg::REG_INTEG_GAIN:
            csr_prdata = {8'd0, cfg_ff.integ_gain};
         pidsp_pkg::REG_DERIV_GAIN:
            csr_prdata = {8'd0, cfg_ff.deriv_gain};
         pidsp_pkg::REG_DRIVE_LIMIT:
            csr_prdata = {17'd0, cfg_ff.drive_limit};
         pidsp_pkg::REG_INTEG_LIMIT:
            csr_prdata = {17'd0, cfg_ff.integ_limit};
         pidsp_pkg::REG_SEPARATION_LEVEL:
            csr_prdata = {16'd0, cfg_ff.separation_level};
         default:
            csr_prdata = '0;
      endcase
   end

endmodule

// ===== sv/pidsp_calc.sv =====
// ----------------------------------------------------------------------------
// PID controller arithmetic
// P, separated and clamped I, and D terms, summed, saturated and floored.
// ----------------------------------------------------------------------------
module pidsp_calc (
   input  pidsp_pkg::cfg_type                      cfg,
   input  logic signed [pidsp_pkg::ERR_W-1:0]      err,
   input  logic signed [pidsp_pkg::ERR_W-1:0]      last_error,
   input  logic signed [pidsp_pkg::ACC_W-1:0]      integ_accum,
   output logic signed [pidsp_pkg::ACC_W-1:0]      integ_next,
   output logic signed [pidsp_pkg::DATA_W-1:0]     drive
);

   logic signed [42:0] p_term;
   logic signed [42:0] i_prod;
   logic signed [43:0] i_sum;
   logic signed [43:0] i_lim;
   logic signed [18:0] d_diff;
   logic signed [43:0] d_term;
   logic signed [45:0] total;
   logic signed [45:0] d_lim;
   logic signed [23:0] total_sat;
   logic               integrate;

   // Proportional term, exact in Q.8
   assign p_term = $signed({1'b0, cfg.prop_gain}) * err;

   // Integral term: accumulate below the separation level, clear otherwise
   assign integrate = err < $signed({{2{cfg.separation_level[15]}}, cfg.separation_level});
   assign i_prod    = $signed({1'b0, cfg.integ_gain}) * err;
   assign i_sum     = {i_prod[42], i_prod} + {{20{integ_accum[23]}}, integ_accum};
   assign i_lim     = $signed({21'd0, cfg.integ_limit, 8'd0});

   always_comb begin
      if (!integrate) begin
         integ_next = '0;
      end else if (i_sum >= i_lim) begin
         integ_next = i_lim[23:0];
      end else if (i_sum <= -i_lim) begin
         integ_next = 24'(-i_lim);
      end else begin
         integ_next = i_sum[23:0];
      end
   end

   // Derivative term on the change in error
   assign d_diff = {err[17], err} - {last_error[17], last_error};
   assign d_term = $signed({1'b0, cfg.deriv_gain}) * d_diff;

   // Sum, saturate to the drive limit, then floor to output units
   assign total = {{3{p_term[42]}}, p_term} + {{22{integ_next[23]}}, integ_next}
                + {{2{d_term[43]}}, d_term};
   assign d_lim = $signed({23'd0, cfg.drive_limit, 8'd0});

   always_comb begin
      if (total >= d_lim) begin
         total_sat = d_lim[23:0];
      end else if (total <= -d_lim) begin
         total_sat = 24'(-d_lim);
      end else begin
         total_sat = total[23:0];
      end
   end

   assign drive = total_sat[23:8];

endmodule

// ===== sv/pid_speed_position_controller_core.sv =====
// ----------------------------------------------------------------------------
// PID speed/position controller core
// Positional PID with integral separation, one drive word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one measured/target word per control tick; rsp_
//   channel returns one saturated drive word for each, in order. Both use
//   valid/ready. Settings must be written over the csr_ APB-style port only
//   while no word is in flight; the block itself does not enforce this.
//   The error (with encoder wrap handling in position mode) is formed into the
//   input register at acceptance, then the three gain products, the clamped
//   integral and the saturated sum are formed combinationally into the result
//   register; rsp_valid rises as the result register is loaded.
//   Throughput is one word per cycle while rsp_ready is high; the integral and
//   last-error state close their loop as the result register loads.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more; req_ready drops only when both are full
//   and rsp_ready is low.
//   Synchronous reset empties both registers, clears the integral and
//   last-error state and loads the register defaults (unity P gain, drive
//   limit 16384).
// ----------------------------------------------------------------------------
module pid_speed_position_controller_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [pidsp_pkg::DATA_W-1:0]    req_measured,
   input  logic signed [pidsp_pkg::DATA_W-1:0]    req_target,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pidsp_pkg::DATA_W-1:0]    rsp_drive,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [pidsp_pkg::ADDR_W-1:0]           csr_paddr,
   input  logic [pidsp_pkg::CSR_W-1:0]            csr_pwdata,
   output logic [pidsp_pkg::CSR_W-1:0]            csr_prdata,
   output logic                                   csr_pready
);

   pidsp_pkg::cfg_type cfg;

   logic                                   s1_valid_ff;
   logic signed [pidsp_pkg::ERR_W-1:0]     s1_err_ff;
   logic signed [pidsp_pkg::ERR_W-1:0]     s1_err_in;
   logic                                   rsp_valid_ff;
   logic signed [pidsp_pkg::DATA_W-1:0]    rsp_drive_ff;
   logic signed [pidsp_pkg::DATA_W-1:0]    drive_in;
   logic signed [pidsp_pkg::ERR_W-1:0]     last_error_ff;
   logic signed [pidsp_pkg::ACC_W-1:0]     integ_accum_ff;
   logic signed [pidsp_pkg::ACC_W-1:0]     integ_accum_in;
   logic signed [pidsp_pkg::DATA_W:0]      diff;
   logic                                   req_take;
   logic                                   s1_advance;

   pidsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake: advance into the result register when it is empty or drained
   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~s1_valid_ff | s1_advance;
   assign req_take   = req_valid & req_ready;

   // Form the error, shifting the measurement by one turn on encoder wrap
   assign diff = {req_target[15], req_target} - {req_measured[15], req_measured};

   always_comb begin
      s1_err_in = {diff[16], diff};
      if (cfg.loop_mode == pidsp_pkg::MODE_POSITION) begin
         if (diff > pidsp_pkg::WRAP_HI) begin
            s1_err_in = {diff[16], diff} - pidsp_pkg::WRAP_SPAN;
         end else if (diff < pidsp_pkg::WRAP_LO) begin
            s1_err_in = {diff[16], diff} + pidsp_pkg::WRAP_SPAN;
         end
      end
   end

   pidsp_calc u_calc (
      .cfg         (cfg),
      .err         (s1_err_ff),
      .last_error  (last_error_ff),
      .integ_accum (integ_accum_ff),
      .integ_next  (integ_accum_in),
      .drive       (drive_in)
   );

   // Control state and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_error_ff  <= '0;
         integ_accum_ff <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff   <= 1'b1;
            last_error_ff  <= s1_err_ff;
            integ_accum_ff <= integ_accum_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_err_ff <= s1_err_in;
      end
      if (s1_advance) begin
         rsp_drive_ff <= drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

// ===== sv/pidsp_checker.sv =====
// ----------------------------------------------------------------------------
// PID controller port checker
// Port-level properties of the controller core, bound to the top level.
// ----------------------------------------------------------------------------
module pidsp_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [pidsp_pkg::DATA_W-1:0]    rsp_drive
);

   // Hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled rsp word changed or dropped");

   // Empty result register after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // An empty result side never blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty result register");

   // Saturated drive never reaches the most negative code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive != 16'sh8000)
      else $error("drive outside symmetric range");

endmodule

bind pid_speed_position_controller_core pidsp_checker u_pidsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_drive (rsp_drive)
);

// ===== tb/tb_pid_speed_position_controller_core.sv =====
// ----------------------------------------------------------------------------
// PID speed/position controller core testbench
// Drives measured/target words into the controller and checks every drive
// word against an in-bench PID predictor that keeps its own copy of the
// settings, the integral term and the previous error. Settings go through
// the APB-style port between traffic phases and are read back to confirm
// field masking. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pid_speed_position_controller_core;

   // One word past the last register; writes there must be dropped
   localparam logic [pidsp_pkg::ADDR_W-1:0] UNMAPPED_ADDR = 5'd28;
   localparam int MAX_REPORTS = 10;

   logic                                   clock = 1'b0;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic signed [pidsp_pkg::DATA_W-1:0]    req_measured;
   logic signed [pidsp_pkg::DATA_W-1:0]    req_target;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic signed [pidsp_pkg::DATA_W-1:0]    rsp_drive;
   logic                                   csr_psel;
   logic                                   csr_penable;
   logic                                   csr_pwrite;
   logic [pidsp_pkg::ADDR_W-1:0]           csr_paddr;
   logic [pidsp_pkg::CSR_W-1:0]            csr_pwdata;
   logic [pidsp_pkg::CSR_W-1:0]            csr_prdata;
   logic                                   csr_pready;

   // Predictor copy of settings and loop state
   pidsp_pkg::cfg_type                     ctrl_cfg;
   logic signed [pidsp_pkg::ERR_W-1:0]     prev_error;
   logic signed [31:0]                     integ_sum;

   logic signed [pidsp_pkg::DATA_W-1:0]    drive_expected[$];
   logic signed [pidsp_pkg::DATA_W-1:0]    drive_want;
   int                                     error_count = 0;
   bit                                     idle_enable = 1'b1;
   int                                     rsp_hold_cycles = 0;

   pid_speed_position_controller_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_measured (req_measured),
      .req_target   (req_target),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic longint saturate(input longint v, input longint lim);
      if (v >= lim) return lim;
      if (v <= -lim) return -lim;
      return v;
   endfunction

   // Advance the loop state by one tick and return the drive word
   function automatic logic signed [pidsp_pkg::DATA_W-1:0] predict_drive(
         input logic signed [pidsp_pkg::DATA_W-1:0] meas_in,
         input logic signed [pidsp_pkg::DATA_W-1:0] tgt_in);
      longint meas, tgt, err, acc, total, ilim, dlim;
      meas = meas_in;
      tgt  = tgt_in;
      // unwrap the encoder angle when the gap passes half a turn
      if (ctrl_cfg.loop_mode == pidsp_pkg::MODE_POSITION) begin
         if (tgt - meas > pidsp_pkg::WRAP_HI) meas = meas + pidsp_pkg::WRAP_SPAN;
         else if (tgt - meas < pidsp_pkg::WRAP_LO) meas = meas - pidsp_pkg::WRAP_SPAN;
      end
      err = tgt - meas;

      // integrate only below the separation level, else clear
      if (err < longint'($signed(ctrl_cfg.separation_level))) begin
         ilim = longint'(ctrl_cfg.integ_limit) * 256;
         acc = longint'(integ_sum) + longint'(ctrl_cfg.integ_gain) * err;
         acc = saturate(acc, ilim);
         integ_sum = acc[31:0];
      end else begin
         integ_sum = '0;
      end

      total = longint'(ctrl_cfg.prop_gain) * err + longint'(integ_sum)
            + longint'(ctrl_cfg.deriv_gain) * (err - longint'(prev_error));
      prev_error = err[pidsp_pkg::ERR_W-1:0];

      // saturate in Q.8, then floor to output units
      dlim = longint'(ctrl_cfg.drive_limit) * 256;
      total = saturate(total, dlim);
      total = total >>> 8;
      return total[pidsp_pkg::DATA_W-1:0];
   endfunction

   function automatic logic [pidsp_pkg::CSR_W-1:0] setting_mask(
         input pidsp_pkg::reg_index_type idx);
      case (idx) inside
         pidsp_pkg::REG_LOOP_MODE:
            return 32'h1;
         pidsp_pkg::REG_PROP_GAIN,
         pidsp_pkg::REG_INTEG_GAIN,
         pidsp_pkg::REG_DERIV_GAIN:
            return {{(pidsp_pkg::CSR_W-pidsp_pkg::GAIN_W){1'b0}},
                    {pidsp_pkg::GAIN_W{1'b1}}};
         pidsp_pkg::REG_DRIVE_LIMIT,
         pidsp_pkg::REG_INTEG_LIMIT:
            return {{(pidsp_pkg::CSR_W-pidsp_pkg::LIMIT_W){1'b0}},
                    {pidsp_pkg::LIMIT_W{1'b1}}};
         default:
            return {{(pidsp_pkg::CSR_W-pidsp_pkg::DATA_W){1'b0}},
                    {pidsp_pkg::DATA_W{1'b1}}};
      endcase
   endfunction

   function automatic logic [pidsp_pkg::CSR_W-1:0] setting_word(
         input pidsp_pkg::reg_index_type idx);
      case (idx)
         pidsp_pkg::REG_LOOP_MODE:   return pidsp_pkg::CSR_W'(ctrl_cfg.loop_mode);
         pidsp_pkg::REG_PROP_GAIN:   return pidsp_pkg::CSR_W'(ctrl_cfg.prop_gain);
         pidsp_pkg::REG_INTEG_GAIN:  return pidsp_pkg::CSR_W'(ctrl_cfg.integ_gain);
         pidsp_pkg::REG_DERIV_GAIN:  return pidsp_pkg::CSR_W'(ctrl_cfg.deriv_gain);
         pidsp_pkg::REG_DRIVE_LIMIT: return pidsp_pkg::CSR_W'(ctrl_cfg.drive_limit);
         pidsp_pkg::REG_INTEG_LIMIT: return pidsp_pkg::CSR_W'(ctrl_cfg.integ_limit);
         default:
            return pidsp_pkg::CSR_W'($unsigned(ctrl_cfg.separation_level));
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch %0d: %s expected %0d got %0d", error_count, what, want, got);
   endfunction

   // ------------------------------------------------------------------------
   // Result checking and receiver stalls
   // ------------------------------------------------------------------------
   // Compare each taken drive word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_expected.size() == 0) begin
            note_mismatch("unexpected drive word", 0, rsp_drive);
         end else begin
            drive_want = drive_expected.pop_front();
            if (rsp_drive !== drive_want) note_mismatch("drive", drive_want, rsp_drive);
         end
      end
   end

   // Drop ready for a drawn number of cycles before each word, or hold off long
   initial begin : rsp_ready_driver
      int gap;
      rsp_ready = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = idle_enable ? $urandom_range(0, 18) : 0;
         end
         if (gap > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // ------------------------------------------------------------------------
   // Sender and register port
   // ------------------------------------------------------------------------
   // Offer one word after a drawn gap, predict it once taken
   task automatic send_word(input logic signed [pidsp_pkg::DATA_W-1:0] meas,
                            input logic signed [pidsp_pkg::DATA_W-1:0] tgt);
      int gap;
      gap = idle_enable ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_measured <= meas;
      req_target   <= tgt;
      do @(posedge clock); while (!req_ready);
      drive_expected.push_back(predict_drive(meas, tgt));
   endtask

   // Stop offering and wait until every predicted word has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
   endtask

   // One APB transfer: setup, access, then return to idle
   task automatic csr_access(input logic write,
                             input logic [pidsp_pkg::ADDR_W-1:0] addr,
                             input logic [pidsp_pkg::CSR_W-1:0] wdata,
                             output logic [pidsp_pkg::CSR_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write one register with junk above the field, keep the model in step
   task automatic write_setting(input pidsp_pkg::reg_index_type idx,
                                input logic [pidsp_pkg::CSR_W-1:0] value);
      logic [pidsp_pkg::CSR_W-1:0] word, discard;
      word = ($urandom() & ~setting_mask(idx)) | (value & setting_mask(idx));
      csr_access(1'b1, {idx, 2'b00}, word, discard);
      case (idx)
         pidsp_pkg::REG_LOOP_MODE:
            ctrl_cfg.loop_mode = word[0];
         pidsp_pkg::REG_PROP_GAIN:
            ctrl_cfg.prop_gain = word[pidsp_pkg::GAIN_W-1:0];
         pidsp_pkg::REG_INTEG_GAIN:
            ctrl_cfg.integ_gain = word[pidsp_pkg::GAIN_W-1:0];
         pidsp_pkg::REG_DERIV_GAIN:
            ctrl_cfg.deriv_gain = word[pidsp_pkg::GAIN_W-1:0];
         pidsp_pkg::REG_DRIVE_LIMIT:
            ctrl_cfg.drive_limit = word[pidsp_pkg::LIMIT_W-1:0];
         pidsp_pkg::REG_INTEG_LIMIT:
            ctrl_cfg.integ_limit = word[pidsp_pkg::LIMIT_W-1:0];
         pidsp_pkg::REG_SEPARATION_LEVEL:
            ctrl_cfg.separation_level = word[pidsp_pkg::DATA_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic mode,
                                 input logic [pidsp_pkg::GAIN_W-1:0] p_gain,
                                 input logic [pidsp_pkg::GAIN_W-1:0] i_gain,
                                 input logic [pidsp_pkg::GAIN_W-1:0] d_gain,
                                 input logic [pidsp_pkg::LIMIT_W-1:0] d_limit,
                                 input logic [pidsp_pkg::LIMIT_W-1:0] i_limit,
                                 input logic signed [pidsp_pkg::DATA_W-1:0] level);
      write_setting(pidsp_pkg::REG_LOOP_MODE, pidsp_pkg::CSR_W'(mode));
      write_setting(pidsp_pkg::REG_PROP_GAIN, pidsp_pkg::CSR_W'(p_gain));
      write_setting(pidsp_pkg::REG_INTEG_GAIN, pidsp_pkg::CSR_W'(i_gain));
      write_setting(pidsp_pkg::REG_DERIV_GAIN, pidsp_pkg::CSR_W'(d_gain));
      write_setting(pidsp_pkg::REG_DRIVE_LIMIT, pidsp_pkg::CSR_W'(d_limit));
      write_setting(pidsp_pkg::REG_INTEG_LIMIT, pidsp_pkg::CSR_W'(i_limit));
      write_setting(pidsp_pkg::REG_SEPARATION_LEVEL, pidsp_pkg::CSR_W'($unsigned(level)));
   endtask

   // Read every register back and compare its field bits
   task automatic check_settings();
      pidsp_pkg::reg_index_type    idx;
      logic [pidsp_pkg::CSR_W-1:0] rd;
      idx = idx.first();
      do begin
         csr_access(1'b0, {idx, 2'b00}, '0, rd);
         if ((rd & setting_mask(idx)) != setting_word(idx))
            note_mismatch(idx.name(), setting_word(idx), rd & setting_mask(idx));
         idx = idx.next();
      end while (idx != idx.first());
   endtask

   function automatic logic [pidsp_pkg::GAIN_W-1:0] pick_gain();
      if ($urandom_range(0, 3) == 0) return pidsp_pkg::GAIN_W'($urandom());
      return pidsp_pkg::GAIN_W'($urandom_range(0, 1024));
   endfunction

   function automatic logic [pidsp_pkg::LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return pidsp_pkg::LIMIT_W'($urandom_range(1, 32766));
      endcase
   endfunction

   // Extremes on the first two phases, random settings after that
   task automatic random_settings(input int phase);
      logic signed [pidsp_pkg::DATA_W-1:0] level;
      case ($urandom_range(0, 4))
         0:       level = pidsp_pkg::DATA_W'($urandom());
         1:       level = 16'sh7FFF;
         2:       level = 16'sh8000;
         default: level = pidsp_pkg::DATA_W'($urandom_range(0, 1000) - 500);
      endcase
      case (phase)
         0:       apply_settings(pidsp_pkg::MODE_POSITION, '1, '1, '1, '1, '1, 16'sh7FFF);
         1:       apply_settings(pidsp_pkg::MODE_SPEED, '0, '0, '0, '0, '0, 16'sh8000);
         default: apply_settings(phase[0] ? pidsp_pkg::MODE_POSITION : pidsp_pkg::MODE_SPEED,
                                 pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                                 pick_limit(), level);
      endcase
   endtask

   // Mostly a drifting setpoint with a nearby measurement, some raw noise
   task automatic run_random_phase(input int count, input bit allow_idle);
      int sp, tgt, meas, offs;
      sp = $urandom_range(0, 8191);
      for (int k = 0; k < count; k++) begin
         idle_enable = allow_idle && ((k / 60) % 3 != 2);
         if ($urandom_range(0, 7) == 0) begin
            send_word(pidsp_pkg::DATA_W'($urandom()), pidsp_pkg::DATA_W'($urandom()));
         end else begin
            sp += $urandom_range(0, 64) - 32;
            if ($urandom_range(0, 4) == 0) offs = $urandom_range(0, 9000) - 4500;
            else offs = $urandom_range(0, 128) - 64;
            if (ctrl_cfg.loop_mode == pidsp_pkg::MODE_POSITION) begin
               tgt  = sp & 8191;
               meas = (sp + offs) & 8191;
            end else begin
               tgt  = sp - 4096;
               meas = tgt + offs;
            end
            send_word(pidsp_pkg::DATA_W'(meas), pidsp_pkg::DATA_W'(tgt));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_values();
      check_settings();
      send_word(16'sd0, 16'sd0);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sh7FFF, 16'sh8000);
      wait_drained();
   endtask

   task automatic test_register_access();
      logic [pidsp_pkg::CSR_W-1:0] discard;
      apply_settings(pidsp_pkg::MODE_POSITION, '1, '1, '1, '1, '1, -16'sd1);
      csr_access(1'b1, UNMAPPED_ADDR, $urandom(), discard);
      check_settings();
      apply_settings(pidsp_pkg::MODE_SPEED, '0, '0, '0, '0, '0, 16'sh8000);
      csr_access(1'b1, UNMAPPED_ADDR, '1, discard);
      check_settings();
   endtask

   task automatic test_speed_extremes();
      apply_settings(pidsp_pkg::MODE_SPEED, '1, '0, '1, '1, '0, 16'sd0);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sh7FFF, 16'sh8000);
      send_word(16'sd0, 16'sd0);
      wait_drained();
      // gain of 1.5 shows floor rounding on both signs
      apply_settings(pidsp_pkg::MODE_SPEED, 24'd384, '0, '0, '1, '0, 16'sd0);
      send_word(16'sd0, 16'sd1);
      send_word(16'sd1, 16'sd0);
      wait_drained();
   endtask

   task automatic test_zero_limits();
      apply_settings(pidsp_pkg::MODE_SPEED, 24'd256, 24'd256, 24'd256, '0, '0, 16'sh7FFF);
      send_word(16'sd0, 16'sd1000);
      send_word(16'sd500, -16'sd700);
      wait_drained();
      apply_settings(pidsp_pkg::MODE_SPEED, '0, '1, '0, '1, '0, 16'sh7FFF);
      send_word(16'sd0, 16'sd1000);
      wait_drained();
   endtask

   task automatic test_position_wrap();
      apply_settings(pidsp_pkg::MODE_POSITION, 24'd256, '0, '0, '1, '0, 16'sd0);
      send_word(16'sd8000, 16'sd100);
      send_word(16'sd100, 16'sd8000);
      send_word(16'sd0, 16'sd4096);
      send_word(16'sd0, 16'sd4097);
      send_word(16'sd4096, 16'sd0);
      send_word(16'sd4097, 16'sd0);
      wait_drained();
   endtask

   task automatic test_integral_separation();
      apply_settings(pidsp_pkg::MODE_SPEED, '0, 24'd256, '0, '1, 15'd100, 16'sd10);
      send_word(16'sd0, 16'sd5);
      send_word(16'sd0, 16'sd5);
      send_word(16'sd0, 16'sd10);
      send_word(16'sd200, 16'sd0);
      send_word(16'sd0, 16'sd20);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         random_settings(phase);
         run_random_phase(170, 1'b1);
         wait_drained();
      end
   endtask

   // Hold the receiver off while words keep coming so the input backs up
   task automatic test_receiver_stall();
      random_settings(2);
      rsp_hold_cycles = 80;
      run_random_phase(24, 1'b0);
      wait_drained();
      idle_enable = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_measured = '0;
      req_target   = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      ctrl_cfg             = '0;
      ctrl_cfg.prop_gain   = pidsp_pkg::PROP_GAIN_RST;
      ctrl_cfg.drive_limit = pidsp_pkg::DRIVE_LIMIT_RST;
      prev_error           = '0;
      integ_sum            = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_register_access();
      test_speed_extremes();
      test_zero_limits();
      test_position_wrap();
      test_integral_separation();
      test_random_traffic();
      test_receiver_stall();

      // let any stray word show up before the verdict
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && drive_expected.size() == 0) begin
         $display("PASS pid_speed_position_controller_core");
      end else begin
         $display("FAIL pid_speed_position_controller_core");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL pid_speed_position_controller_core");
      $finish;
   end

endmodule
